FILE: rtl/lrc_pkg.sv
package lrc_pkg;

	localparam int VAR_W = 10;
	localparam int REG_W = 3;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mark_ctl_t;

endpackage

FILE: rtl/lru_register_cache_top.sv
// Register cache: each input word carries a variable id and yields one result word
// giving the register assigned to it, with hit, spill and reload flags. Up to one word
// is taken per cycle while in_stall is low; the id first lands in an input register
// together with its registered spill-mark read, and the tag compare, move-to-front
// update and spill-mark write then finish into the result register, which holds while
// out_stall is high. After reset the spill-mark memory is cleared one entry per cycle,
// and in_stall stays high until the clearing is done.
module lru_register_cache_top #(
	parameter int NUM_SLOTS = 6,
	parameter int MAX_VARS  = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [lrc_pkg::VAR_W-1:0] var_id,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [lrc_pkg::REG_W-1:0] reg_index,
	output logic                      was_hit,
	output logic                      spill_needed,
	output logic [lrc_pkg::VAR_W-1:0] spill_var,
	output logic                      reload_needed
);

	localparam int IW   = $clog2(MAX_VARS);
	localparam int PW   = $clog2(NUM_SLOTS);
	localparam int LAST = NUM_SLOTS - 1;
	localparam int RW   = IW + 6;

	logic [lrc_pkg::VAR_W-1:0] tag_q [NUM_SLOTS];
	logic [lrc_pkg::REG_W-1:0] reg_q [NUM_SLOTS];
	logic [IW-1:0]             idx_q [NUM_SLOTS];

	logic                      valid_s1;
	logic [lrc_pkg::VAR_W-1:0] id_s1;
	logic [IW-1:0]             idx_s1;

	logic                      out_valid_q;
	logic [lrc_pkg::REG_W-1:0] reg_index_q;
	logic                      was_hit_q;
	logic                      spill_needed_q;
	logic [lrc_pkg::VAR_W-1:0] spill_var_q;
	logic                      reload_needed_q;

	logic                      accept;
	logic                      out_free;
	logic                      s1_go;
	logic                      mark;
	logic                      mark_busy;
	lrc_pkg::mark_ctl_t        mark_ctl;
	logic [RW-1:0]             rem;
	logic [IW-1:0]             in_idx;

	logic                      hit_any;
	logic [PW-1:0]             hit_pos;
	logic                      empty_any;
	logic [PW-1:0]             empty_pos;
	logic                      evict;
	logic [PW-1:0]             pos;
	logic [lrc_pkg::VAR_W-1:0] front_tag;
	logic [lrc_pkg::REG_W-1:0] front_reg;
	logic [IW-1:0]             front_idx;
	logic [lrc_pkg::VAR_W-1:0] nxt_tag [NUM_SLOTS];
	logic [lrc_pkg::REG_W-1:0] nxt_reg [NUM_SLOTS];
	logic [IW-1:0]             nxt_idx [NUM_SLOTS];
	logic [lrc_pkg::REG_W-1:0] res_reg;
	logic                      res_hit;
	logic                      res_spill;
	logic [lrc_pkg::VAR_W-1:0] res_var;
	logic                      res_reload;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = mark_busy || (valid_s1 && !out_free);
	assign accept   = in_valid && !in_stall;
	assign s1_go    = valid_s1 && out_free && (id_s1 != '0);

	// id modulo MAX_VARS by binary compare and subtract
	always_comb begin
		rem = RW'(var_id);
		for (int k = 5; k >= 0; k--) begin
			if (rem >= (RW'(MAX_VARS) << k)) begin
				rem = rem - (RW'(MAX_VARS) << k);
			end
		end
		in_idx = rem[IW-1:0];
	end

	assign mark_ctl.rd_en = accept;
	assign mark_ctl.wr_en = s1_go && evict;

	lrc_mark_store #(
		.DEPTH(MAX_VARS)
	) u_mark (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mark_ctl),
		.rd_idx (in_idx),
		.wr_idx (idx_q[LAST]),
		.mark   (mark),
		.busy   (mark_busy)
	);

	always_comb begin
		hit_any   = 1'b0;
		hit_pos   = '0;
		empty_any = 1'b0;
		empty_pos = '0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			if (!hit_any && (tag_q[k] == id_s1)) begin
				hit_any = 1'b1;
				hit_pos = PW'(k);
			end
			if (!empty_any && (tag_q[k] == '0)) begin
				empty_any = 1'b1;
				empty_pos = PW'(k);
			end
		end
		evict = !hit_any && !empty_any;

		priority if (hit_any) begin
			pos       = hit_pos;
			front_tag = tag_q[hit_pos];
			front_reg = reg_q[hit_pos];
			front_idx = idx_q[hit_pos];
		end else if (empty_any) begin
			pos       = empty_pos;
			front_tag = id_s1;
			front_reg = lrc_pkg::REG_W'(empty_pos);
			front_idx = idx_s1;
		end else begin
			pos       = PW'(LAST);
			front_tag = id_s1;
			front_reg = reg_q[LAST];
			front_idx = idx_s1;
		end

		// move to front: slots above the chosen one shift down by one
		nxt_tag[0] = front_tag;
		nxt_reg[0] = front_reg;
		nxt_idx[0] = front_idx;
		for (int j = 1; j < NUM_SLOTS; j++) begin
			if (PW'(j) <= pos) begin
				nxt_tag[j] = tag_q[j-1];
				nxt_reg[j] = reg_q[j-1];
				nxt_idx[j] = idx_q[j-1];
			end else begin
				nxt_tag[j] = tag_q[j];
				nxt_reg[j] = reg_q[j];
				nxt_idx[j] = idx_q[j];
			end
		end

		if (id_s1 == '0) begin
			res_reg    = '0;
			res_hit    = 1'b0;
			res_spill  = 1'b0;
			res_var    = '0;
			res_reload = 1'b0;
		end else begin
			res_reg    = front_reg;
			res_hit    = hit_any;
			res_spill  = evict;
			res_var    = evict ? tag_q[LAST] : '0;
			// victim and requester may share a mark entry
			res_reload = evict && (mark || (idx_q[LAST] == idx_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				tag_q[k] <= '0;
				reg_q[k] <= '0;
				idx_q[k] <= '0;
			end
		end else if (s1_go) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				tag_q[k] <= nxt_tag[k];
				reg_q[k] <= nxt_reg[k];
				idx_q[k] <= nxt_idx[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_s1  <= var_id;
			idx_s1 <= in_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			reg_index_q     <= res_reg;
			was_hit_q       <= res_hit;
			spill_needed_q  <= res_spill;
			spill_var_q     <= res_var;
			reload_needed_q <= res_reload;
		end
	end

	assign out_valid     = out_valid_q;
	assign reg_index     = reg_index_q;
	assign was_hit       = was_hit_q;
	assign spill_needed  = spill_needed_q;
	assign spill_var     = spill_var_q;
	assign reload_needed = reload_needed_q;

	a_hit_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(was_hit && spill_needed))
		else $error("hit word also flags a spill");

	a_reload_spill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && reload_needed) |-> spill_needed)
		else $error("reload without eviction");

	a_spill_var: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && spill_needed) |-> (spill_var != '0))
		else $error("spill of an empty slot");

	a_clear_block: assert property (@(posedge clk) disable iff (!arst_n)
		mark_busy |-> in_stall)
		else $error("word accepted during mark clearing");

endmodule

FILE: rtl/lrc_mark_store.sv
module lrc_mark_store #(
	parameter int DEPTH = 1024,
	localparam int IW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lrc_pkg::mark_ctl_t ctl,
	input  logic [IW-1:0]     rd_idx,
	input  logic [IW-1:0]     wr_idx,
	output logic              mark,
	output logic              busy
);

	logic          mem [DEPTH];
	logic          rd_q;
	logic          fwd_q;
	logic          busy_q;
	logic [IW-1:0] clr_q;
	logic          we;
	logic [IW-1:0] wa;

	// clearing pass owns the write port until every entry is zero
	assign we = busy_q || ctl.wr_en;
	assign wa = busy_q ? clr_q : wr_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + IW'(1);
			if (clr_q == IW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= !busy_q;
		end
		if (ctl.rd_en) begin
			rd_q  <= mem[rd_idx];
			// a mark set at the same edge is seen by the read
			fwd_q <= ctl.wr_en && (wr_idx == rd_idx);
		end
	end

	assign mark = rd_q || fwd_q;
	assign busy = busy_q;

endmodule

FILE: sim/tb_lru_register_cache_top.sv
`timescale 1ns / 100ps

module tb_lru_register_cache_top;

	localparam int VAR_W       = lrc_pkg::VAR_W;
	localparam int REG_W       = lrc_pkg::REG_W;
	localparam int NUM_SLOTS   = 6;
	localparam int MAX_VARS    = 1024;
	localparam int LAST_SLOT   = NUM_SLOTS - 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AFTER  = 250;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [REG_W-1:0] rnum;
		logic             hit;
		logic             spill;
		logic [VAR_W-1:0] victim;
		logic             reload;
	} alloc_t;

	typedef struct {
		logic [VAR_W-1:0] id;
		int               gap;
	} request_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [VAR_W-1:0] var_id = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [REG_W-1:0] reg_index;
	logic             was_hit;
	logic             spill_needed;
	logic [VAR_W-1:0] spill_var;
	logic             reload_needed;

	// predictor state
	logic [VAR_W-1:0] cache_tag [NUM_SLOTS];
	logic [REG_W-1:0] cache_reg [NUM_SLOTS];
	logic             was_spilled [MAX_VARS];

	request_t pending_ids [$];
	alloc_t   expected_allocs [$];

	logic id_taken = 1'b0;
	int   gap_left = 0;
	int   stall_left = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	int   ids_accepted = 0;
	int   results_seen = 0;
	int   fail_count = 0;
	int   reported = 0;
	int   cycles = 0;
	int   n_hits = 0;
	int   n_spills = 0;
	int   n_reloads = 0;
	int   n_nulls = 0;

	lru_register_cache_top #(
		.NUM_SLOTS(NUM_SLOTS),
		.MAX_VARS (MAX_VARS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.var_id       (var_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.reg_index    (reg_index),
		.was_hit      (was_hit),
		.spill_needed (spill_needed),
		.spill_var    (spill_var),
		.reload_needed(reload_needed)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void move_to_front(input int pos);
		logic [VAR_W-1:0] t;
		logic [REG_W-1:0] g;
		t = cache_tag[pos];
		g = cache_reg[pos];
		for (int j = pos; j > 0; j--) begin
			cache_tag[j] = cache_tag[j-1];
			cache_reg[j] = cache_reg[j-1];
		end
		cache_tag[0] = t;
		cache_reg[0] = g;
	endfunction

	function automatic alloc_t allocate_register(input logic [VAR_W-1:0] id);
		alloc_t r;
		int     found;
		int     empty;
		r = '0;
		found = -1;
		empty = -1;
		if (id != '0) begin
			for (int k = 0; k < NUM_SLOTS; k++)
				if (found < 0 && cache_tag[k] == id) found = k;
			if (found >= 0) begin
				move_to_front(found);
				r.rnum = cache_reg[0];
				r.hit  = 1'b1;
			end else begin
				for (int k = 0; k < NUM_SLOTS; k++)
					if (empty < 0 && cache_tag[k] == '0) empty = k;
				if (empty >= 0) begin
					cache_tag[empty] = id;
					cache_reg[empty] = REG_W'(empty);
					move_to_front(empty);
					r.rnum = REG_W'(empty);
				end else begin
					r.victim = cache_tag[LAST_SLOT];
					r.rnum   = cache_reg[LAST_SLOT];
					r.spill  = 1'b1;
					was_spilled[r.victim] = 1'b1;
					r.reload = was_spilled[id];
					cache_tag[LAST_SLOT] = id;
					move_to_front(LAST_SLOT);
				end
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// sender
	always @(negedge clk) begin
		if (arst_n && (!in_valid || id_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_ids.size() > 0) begin
				request_t q;
				q = pending_ids.pop_front();
				in_valid <= 1'b1;
				var_id   <= q.id;
				gap_left <= q.gap;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with one long hold-off once traffic is under way
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && ids_accepted >= HOLD_AFTER) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				hold_done <= 1'b1;
			end else if (stall_left > 0) begin
				out_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else if ((results_seen / 80) % 3 == 1 || $urandom_range(0, 99) < 75) begin
				out_stall <= 1'b0;
			end else begin
				out_stall  <= 1'b1;
				stall_left <= pick_gap();
			end
		end
	end

	// result check and input capture
	always @(posedge clk) begin
		if (arst_n) begin
			id_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				alloc_t e;
				results_seen++;
				if (expected_allocs.size() == 0) begin
					fail_count++;
					if (reported < 10) begin
						reported++;
						$display("unexpected result word: reg=%0d hit=%0b spill=%0b var=%0d reload=%0b",
							reg_index, was_hit, spill_needed, spill_var, reload_needed);
					end
				end else begin
					e = expected_allocs.pop_front();
					if (reg_index !== e.rnum || was_hit !== e.hit || spill_needed !== e.spill ||
						spill_var !== e.victim || reload_needed !== e.reload) begin
						fail_count++;
						if (reported < 10) begin
							reported++;
							$display("mismatch: expected reg=%0d hit=%0b spill=%0b var=%0d reload=%0b",
								e.rnum, e.hit, e.spill, e.victim, e.reload);
							$display("          actual   reg=%0d hit=%0b spill=%0b var=%0d reload=%0b",
								reg_index, was_hit, spill_needed, spill_var, reload_needed);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				alloc_t p;
				p = allocate_register(var_id);
				expected_allocs.push_back(p);
				ids_accepted++;
				if (var_id == '0) n_nulls++;
				if (p.hit) n_hits++;
				if (p.spill) n_spills++;
				if (p.reload) n_reloads++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [VAR_W-1:0] directed [];
		logic [VAR_W-1:0] pool [$];
		request_t         q;
		bit               no_gaps;
		int               r;

		directed = '{
			10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd3, 10'd3, 10'd6,
			10'd1023, 10'd512, 10'd1, 10'd2, 10'd341, 10'd682, 10'd1023, 10'd0, 10'd4, 10'd1
		};

		for (int k = 0; k < NUM_SLOTS; k++) begin
			cache_tag[k] = '0;
			cache_reg[k] = '0;
		end
		for (int k = 0; k < MAX_VARS; k++)
			was_spilled[k] = 1'b0;

		foreach (directed[i]) begin
			q.id  = directed[i];
			q.gap = (i < 10) ? 0 : pick_gap();
			pending_ids.push_back(q);
		end

		// blocks of requests drawn from a small working set so hits, spills and reloads recur
		for (int b = 0; b < 12; b++) begin
			pool.delete();
			r = $urandom_range(7, 12);
			for (int k = 0; k < r; k++)
				pool.push_back(VAR_W'($urandom_range(1, 1023)));
			no_gaps = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < 50; n++) begin
				r = $urandom_range(0, 99);
				if (r < 80) q.id = pool[$urandom_range(0, pool.size() - 1)];
				else if (r < 95) q.id = VAR_W'($urandom_range(1, 1023));
				else q.id = '0;
				q.gap = no_gaps ? 0 : pick_gap();
				pending_ids.push_back(q);
			end
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_ids.size() > 0 || in_valid || expected_allocs.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (expected_allocs.size() > 0) begin
			fail_count += expected_allocs.size();
			$display("%0d expected results never arrived", expected_allocs.size());
		end

		$display("covered %0d request words (%0d null ids), %0d hits, %0d spills, %0d reloads",
			ids_accepted, n_nulls, n_hits, n_spills, n_reloads);
		$display("%0d result words checked, %0d failures", results_seen, fail_count);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
